[hw/rtl/ctlu_pkg.sv]
// shared constants and types for the cpu tick line utilization block
// no dependencies

package ctlu_pkg;

	localparam int COUNTER_BITS = 48;
	localparam int TOTAL_BITS   = COUNTER_BITS + 3;
	localparam int IDLE_BITS    = COUNTER_BITS + 1;
	localparam int REM_BITS     = TOTAL_BITS + 7;
	localparam int FIELD_BITS   = 4;
	localparam int PCT_BITS     = 7;

	localparam logic [FIELD_BITS-1:0] MAX_FIELDS   = 4'd10;
	localparam logic [FIELD_BITS-1:0] TOTAL_FIELDS = 4'd8;
	localparam logic [FIELD_BITS-1:0] IDLE_FIELD_A = 4'd3;
	localparam logic [FIELD_BITS-1:0] IDLE_FIELD_B = 4'd4;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

	localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [TOTAL_BITS-1:0] total;
		logic [IDLE_BITS-1:0]  idle;
		logic [FIELD_BITS-1:0] count;
	} line_sum_t;

endpackage

[hw/rtl/cpu_tick_line_utilization.sv]
// top level of the cpu tick line utilization block
// depends on ctlu_pkg, ctlu_front, ctlu_queue, ctlu_back
//
// s_* channel: one ascii byte of a tick-counter line per word. bytes before the
// first digit of a line are dropped; any non-digit ends a field; up to ten fields
// are parsed, each saturating at the counter width. a newline closes the line.
// m_* channel: one word per closed line with busy percent (0..100), the field
// count and a first-line flag on tuser.
// throughput: one byte per cycle on the input. the back part takes each line
// through delta, compare, scale by 100, then a 7-step restoring divide, one
// quotient bit per cycle; early cases go from compare straight to the output
// step. a two-entry line queue absorbs short lines, and the input stalls only
// when that queue is full. a finished line sum passes through the queue before
// the back part takes it, and the result word is registered in the output step.
// reset clears the parser, queue, previous-line sums and output valid; the next
// line is treated as the first. when m_tready is low the result word holds and
// the back part waits, while the front keeps parsing into the queue.

module cpu_tick_line_utilization (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // busy_percent[6:0], fields_seen[10:7], zero fill
	output logic        m_tuser    // first_sample
);
	import ctlu_pkg::*;

	line_sum_t q_wdata;
	line_sum_t q_rdata;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	ctlu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	ctlu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	ctlu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[hw/rtl/ctlu_front.sv]
// front part: parses the byte stream into per-line tick sums
// depends on ctlu_pkg

module ctlu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                q_full,
	output logic                q_push,
	output ctlu_pkg::line_sum_t q_wdata
);
	import ctlu_pkg::*;

	localparam logic PH_WAIT  = 1'b0;
	localparam logic PH_PARSE = 1'b1;

	logic                    phase_q;
	logic                    in_num_q;
	logic [FIELD_BITS-1:0]   idx_q;
	logic [COUNTER_BITS-1:0] fv_q;
	logic [TOTAL_BITS-1:0]   total_q;
	logic [IDLE_BITS-1:0]    idle_q;

	logic                    accept;
	logic                    is_digit;
	logic                    is_newline;
	logic [3:0]              digit;
	logic [COUNTER_BITS+3:0] fv_next_wide;
	logic [COUNTER_BITS-1:0] fv_next;
	logic [TOTAL_BITS-1:0]   total_c;
	logic [IDLE_BITS-1:0]    idle_c;
	logic [FIELD_BITS-1:0]   idx_c;

	assign s_tready   = !q_full;
	assign accept     = s_tvalid && s_tready;
	assign is_digit   = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
	assign is_newline = (s_tdata == CHAR_NEWLINE);
	assign digit      = 4'(s_tdata - CHAR_ZERO);

	// saturating multiply by ten plus digit
	always_comb begin
		fv_next_wide = ((COUNTER_BITS+4)'(fv_q) << 3) + ((COUNTER_BITS+4)'(fv_q) << 1)
			+ (COUNTER_BITS+4)'(digit);
		if (fv_next_wide[COUNTER_BITS+3:COUNTER_BITS] != 4'd0) begin
			fv_next = '1;
		end else begin
			fv_next = fv_next_wide[COUNTER_BITS-1:0];
		end
	end

	// field commit
	always_comb begin
		total_c = total_q;
		idle_c  = idle_q;
		idx_c   = idx_q;
		if (in_num_q) begin
			if (idx_q < TOTAL_FIELDS) begin
				total_c = total_q + TOTAL_BITS'(fv_q);
			end
			if (idx_q == IDLE_FIELD_A || idx_q == IDLE_FIELD_B) begin
				idle_c = idle_q + IDLE_BITS'(fv_q);
			end
			idx_c = idx_q + 4'd1;
		end
	end

	assign q_push        = accept && (phase_q == PH_PARSE) && !is_digit && is_newline;
	assign q_wdata.total = total_c;
	assign q_wdata.idle  = idle_c;
	assign q_wdata.count = idx_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			in_num_q <= 1'b0;
			idx_q    <= '0;
			fv_q     <= '0;
			total_q  <= '0;
			idle_q   <= '0;
		end else if (accept) begin
			if (is_digit) begin
				phase_q <= PH_PARSE;
				if (idx_q < MAX_FIELDS) begin
					fv_q     <= fv_next;
					in_num_q <= 1'b1;
				end
			end else if (phase_q == PH_PARSE) begin
				if (is_newline) begin
					phase_q  <= PH_WAIT;
					in_num_q <= 1'b0;
					idx_q    <= '0;
					fv_q     <= '0;
					total_q  <= '0;
					idle_q   <= '0;
				end else if (in_num_q) begin
					in_num_q <= 1'b0;
					idx_q    <= idx_c;
					fv_q     <= '0;
					total_q  <= total_c;
					idle_q   <= idle_c;
				end
			end
		end
	end

endmodule

[hw/rtl/ctlu_queue.sv]
// short queue of finished line sums between front and back parts
// depends on ctlu_pkg

module ctlu_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ctlu_pkg::line_sum_t wdata,
	input  logic                pop,
	output ctlu_pkg::line_sum_t rdata,
	output logic                full,
	output logic                empty
);
	import ctlu_pkg::*;

	line_sum_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/ctlu_back.sv]
// back part: deltas against the previous line, bit-serial percent divide, output register
// depends on ctlu_pkg

module ctlu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  ctlu_pkg::line_sum_t q_rdata,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,
	output logic                m_tuser
);
	import ctlu_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_SUB  = 3'd1;
	localparam logic [2:0] B_CHK  = 3'd2;
	localparam logic [2:0] B_MUL  = 3'd3;
	localparam logic [2:0] B_DIV  = 3'd4;
	localparam logic [2:0] B_FIN  = 3'd5;

	logic [2:0]            st_q;
	logic                  have_prev_q;
	logic [TOTAL_BITS-1:0] prev_total_q;
	logic [IDLE_BITS-1:0]  prev_idle_q;
	logic                  out_valid_q;
	logic [2:0]            cnt_q;

	line_sum_t             cur_q;
	logic [TOTAL_BITS:0]   dt_q;
	logic [IDLE_BITS:0]    di_q;
	logic                  first_q;
	logic [TOTAL_BITS-1:0] num_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [REM_BITS-1:0]   div_q;
	logic [PCT_BITS-1:0]   pct_q;
	logic [PCT_BITS-1:0]   out_pct_q;
	logic                  out_first_q;
	logic [FIELD_BITS-1:0] out_count_q;

	logic [TOTAL_BITS-1:0] di_ext;
	logic                  out_free;
	logic                  q_bit;

	assign q_pop    = (st_q == B_IDLE) && !q_empty;
	assign out_free = !out_valid_q || m_tready;
	assign di_ext   = TOTAL_BITS'(di_q[IDLE_BITS-1:0]);
	assign q_bit    = (rem_q >= div_q);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_first_q;
	assign m_tdata  = {5'd0, out_count_q, out_pct_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= B_IDLE;
			have_prev_q  <= 1'b0;
			prev_total_q <= '0;
			prev_idle_q  <= '0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (st_q == B_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				B_IDLE: begin
					if (!q_empty) begin
						st_q <= B_SUB;
					end
				end
				B_SUB: begin
					prev_total_q <= cur_q.total;
					prev_idle_q  <= cur_q.idle;
					have_prev_q  <= 1'b1;
					st_q         <= B_CHK;
				end
				B_CHK: begin
					priority if (first_q || dt_q[TOTAL_BITS] ||
						dt_q[TOTAL_BITS-1:0] == '0 || di_q[IDLE_BITS] ||
						di_ext >= dt_q[TOTAL_BITS-1:0] || di_ext == '0) begin
						st_q <= B_FIN;
					end else begin
						st_q <= B_MUL;
					end
				end
				B_MUL: begin
					cnt_q <= 3'(PCT_BITS - 1);
					st_q  <= B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == '0) begin
						st_q <= B_FIN;
					end
				end
				B_FIN: begin
					if (out_free) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					cur_q <= q_rdata;
				end
			end
			B_SUB: begin
				dt_q    <= {1'b0, cur_q.total} - {1'b0, prev_total_q};
				di_q    <= {1'b0, cur_q.idle} - {1'b0, prev_idle_q};
				first_q <= !have_prev_q;
			end
			B_CHK: begin
				num_q <= dt_q[TOTAL_BITS-1:0] - di_ext;
				priority if (first_q) begin
					pct_q <= '0;
				end else if (dt_q[TOTAL_BITS] || dt_q[TOTAL_BITS-1:0] == '0) begin
					pct_q <= '0;
				end else if (di_q[IDLE_BITS]) begin
					pct_q <= PCT_FULL;
				end else if (di_ext >= dt_q[TOTAL_BITS-1:0]) begin
					pct_q <= '0;
				end else if (di_ext == '0) begin
					pct_q <= PCT_FULL;
				end else begin
					pct_q <= '0;
				end
			end
			B_MUL: begin
				// times 100 as 64 + 32 + 4
				rem_q <= (REM_BITS'(num_q) << 6) + (REM_BITS'(num_q) << 5)
					+ (REM_BITS'(num_q) << 2);
				div_q <= REM_BITS'(dt_q[TOTAL_BITS-1:0]) << (PCT_BITS - 1);
				pct_q <= '0;
			end
			B_DIV: begin
				if (q_bit) begin
					rem_q <= rem_q - div_q;
				end
				div_q <= div_q >> 1;
				pct_q <= {pct_q[PCT_BITS-2:0], q_bit};
			end
			B_FIN: begin
				if (out_free) begin
					out_pct_q   <= pct_q;
					out_first_q <= first_q;
					out_count_q <= cur_q.count;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/ctlu_checker.sv]
// port-level checks for cpu_tick_line_utilization, attached by bind
// depends on cpu_tick_line_utilization

module ctlu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] <= 7'd100))
		else $error("busy percent above 100");

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[6:0] == 7'd0))
		else $error("first line with nonzero percent");

	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[10:7] != 4'd0 && m_tdata[10:7] <= 4'd10))
		else $error("field count out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result word dropped or changed while stalled");

endmodule

bind cpu_tick_line_utilization ctlu_checker u_ctlu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
